FILE: src/trimmed_mean_sensor_normalizer_top_macros.svh
// assertion macros shared by the checker
`ifndef TRIMMED_MEAN_SENSOR_NORMALIZER_TOP_MACROS_SVH
`define TRIMMED_MEAN_SENSOR_NORMALIZER_TOP_MACROS_SVH

// same-cycle implication
`define TMSN_CHK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TMSN_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/tmsn_pkg.sv
package tmsn_pkg;

    localparam int C_SAMPLE_BITS  = 12;
    localparam int C_LANES        = 5;
    localparam int C_ROUND_LEN    = 5;
    localparam int C_ROUND_BITS   = 3;
    // five samples, 300 times full scale, three times a span
    localparam int C_SUM_BITS     = C_SAMPLE_BITS + 3;
    localparam int C_NUM_BITS     = C_SAMPLE_BITS + 9;
    localparam int C_DEN_BITS     = C_SAMPLE_BITS + 2;
    localparam int C_LEVEL_BITS   = 8;
    localparam int C_STEP_BITS    = 3;
    localparam int C_CFG_IDX_BITS = 3;

    localparam int C_SCALE_TOP = 300;
    localparam int C_SCALE_MID = 100;
    localparam int C_DEN_MUL   = 3;
    localparam int C_LEVEL_TOP = 155;

    localparam logic [C_SAMPLE_BITS-1:0] C_FULL_RESET  = '1;
    localparam logic [C_SAMPLE_BITS-1:0] C_FLOOR_RESET = '0;

    typedef enum logic [C_CFG_IDX_BITS-1:0] {
        REG_FULL_SCALE = 3'd0,
        REG_FLOOR_CH0  = 3'd1,
        REG_FLOOR_CH1  = 3'd2,
        REG_FLOOR_CH2  = 3'd3,
        REG_FLOOR_CH3  = 3'd4,
        REG_FLOOR_CH4  = 3'd5
    } t_cfg_reg;

    typedef enum logic [2:0] {
        L_IDLE,
        L_PREP,
        L_CHECK,
        L_DIV,
        L_DONE
    } t_lane_state;

    typedef logic [C_SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample sample_ch0;
        t_sample sample_ch1;
        t_sample sample_ch2;
        t_sample sample_ch3;
        t_sample sample_ch4;
    } t_in_word;

    typedef struct packed {
        logic [C_LEVEL_BITS-1:0] level_ch0;
        logic [C_LEVEL_BITS-1:0] level_ch1;
        logic [C_LEVEL_BITS-1:0] level_ch2;
        logic [C_LEVEL_BITS-1:0] level_ch3;
        logic [C_LEVEL_BITS-1:0] level_ch4;
        logic                    bad_range;
    } t_out_word;

    // running round figures of one channel, including the sample at hand
    typedef struct packed {
        logic [C_SUM_BITS-1:0] sum;
        t_sample               min;
        t_sample               max;
    } t_round_stat;

    // lane status toward the merge stage
    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic [C_LEVEL_BITS-1:0] level;
        logic                    bad;
    } t_lane_stat;

endpackage

FILE: src/tmsn_acc.sv
module tmsn_acc (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic                 i_last,
    input  tmsn_pkg::t_sample    i_sample,
    output tmsn_pkg::t_round_stat o_round
);
    import tmsn_pkg::*;

    logic [C_SUM_BITS-1:0] r_sum, n_sum;
    t_sample               r_min, n_min;
    t_sample               r_max, n_max;
    t_round_stat           upd;

    always_comb begin
        upd.sum = r_sum + C_SUM_BITS'(i_sample);
        upd.min = (i_sample < r_min) ? i_sample : r_min;
        upd.max = (i_sample > r_max) ? i_sample : r_max;
        n_sum   = r_sum;
        n_min   = r_min;
        n_max   = r_max;
        if (i_take) begin
            if (i_last) begin
                n_sum = '0;
                n_min = '1;
                n_max = '0;
            end else begin
                n_sum = upd.sum;
                n_min = upd.min;
                n_max = upd.max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_min <= '1;
            r_max <= '0;
        end else begin
            r_sum <= n_sum;
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    assign o_round = upd;

endmodule

FILE: src/tmsn_level.sv
module tmsn_level (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  tmsn_pkg::t_round_stat i_round,
    input  tmsn_pkg::t_sample     i_full,
    input  tmsn_pkg::t_sample     i_floor,
    input  logic                  i_ack,
    output tmsn_pkg::t_lane_stat  o_stat
);
    import tmsn_pkg::*;

    t_lane_state             r_state, n_state;
    t_round_stat             r_round;
    t_sample                 r_full;
    t_sample                 r_floor;
    logic [C_NUM_BITS-1:0]   r_num;
    logic                    r_neg;
    logic [C_DEN_BITS-1:0]   r_den;
    logic                    r_bad;
    logic [C_NUM_BITS-1:0]   r_rem;
    logic [C_LEVEL_BITS-1:0] r_quo;
    logic [C_STEP_BITS-1:0]  r_step;

    logic [C_SUM_BITS-1:0]   mid;
    logic [C_NUM_BITS-1:0]   pos_term;
    logic [C_NUM_BITS-1:0]   neg_term;
    logic [C_SAMPLE_BITS-1:0] span;
    logic [C_NUM_BITS-1:0]   sat_lim;
    logic [C_NUM_BITS-1:0]   trial;
    logic                    shortcut;

    always_comb begin
        mid      = r_round.sum - C_SUM_BITS'(r_round.min) - C_SUM_BITS'(r_round.max);
        pos_term = C_NUM_BITS'(r_full) * C_NUM_BITS'(C_SCALE_TOP);
        neg_term = C_NUM_BITS'(mid) * C_NUM_BITS'(C_SCALE_MID);
        span     = r_full - r_floor;
        sat_lim  = C_NUM_BITS'(r_den) * C_NUM_BITS'(C_LEVEL_TOP + 1);
        trial    = C_NUM_BITS'(r_den) << r_step;
        shortcut = r_bad || r_neg || (r_num >= sat_lim);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            L_IDLE:  if (i_start) n_state = L_PREP;
            L_PREP:  n_state = L_CHECK;
            L_CHECK: n_state = shortcut ? L_DONE : L_DIV;
            L_DIV:   if (r_step == '0) n_state = L_DONE;
            L_DONE:  if (i_ack) n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath: prepare numerator and divisor, check for a settled level, then one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    r_round <= i_round;
                    r_full  <= i_full;
                    r_floor <= i_floor;
                end
            end
            L_PREP: begin
                r_num <= pos_term - neg_term;
                r_neg <= neg_term > pos_term;
                r_den <= C_DEN_BITS'(span) * C_DEN_BITS'(C_DEN_MUL);
                r_bad <= r_floor >= r_full;
            end
            L_CHECK: begin
                r_rem  <= r_num;
                r_step <= C_STEP_BITS'(C_LEVEL_BITS - 1);
                if (r_bad || r_neg) begin
                    r_quo <= '0;
                end else if (r_num >= sat_lim) begin
                    r_quo <= C_LEVEL_BITS'(C_LEVEL_TOP);
                end else begin
                    r_quo <= '0;
                end
            end
            L_DIV: begin
                if (r_rem >= trial) begin
                    r_rem         <= r_rem - trial;
                    r_quo[r_step] <= 1'b1;
                end
                r_step <= r_step - 1'b1;
            end
            L_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        o_stat.busy  = (r_state != L_IDLE);
        o_stat.done  = (r_state == L_DONE);
        o_stat.level = r_quo;
        o_stat.bad   = r_bad;
    end

endmodule

FILE: src/tmsn_merge.sv
module tmsn_merge (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  tmsn_pkg::t_lane_stat [tmsn_pkg::C_LANES-1:0] i_stat,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output tmsn_pkg::t_out_word                    o_out_data,
    output logic                                   o_ack
);
    import tmsn_pkg::*;

    logic      r_valid;
    t_out_word r_word, n_word;
    logic      all_done;
    logic      any_bad;
    logic      load;

    always_comb begin
        all_done = 1'b1;
        any_bad  = 1'b0;
        for (int c = 0; c < C_LANES; c++) begin
            all_done = all_done & i_stat[c].done;
            any_bad  = any_bad | i_stat[c].bad;
        end
        load             = all_done && (!r_valid || !i_out_stall);
        n_word.level_ch0 = i_stat[0].level;
        n_word.level_ch1 = i_stat[1].level;
        n_word.level_ch2 = i_stat[2].level;
        n_word.level_ch3 = i_stat[3].level;
        n_word.level_ch4 = i_stat[4].level;
        n_word.bad_range = any_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= n_word;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_word;
    assign o_ack       = load;

endmodule

FILE: src/trimmed_mean_sensor_normalizer_top.sv
// from the fifth word of a round, each lane runs prep and check, divides unless the check settles
//   the level, and waits in done; the merge stage registers the result word once every lane is done
// one input word a cycle; the fifth word of a round waits while the lane dividers still hold the previous round
// the division is restoring, one quotient bit a cycle in each of five channel lanes
// reset (i_rst_n low, synchronous): round state cleared, full scale 4095, floors 0
module trimmed_mean_sensor_normalizer_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // input word channel
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  tmsn_pkg::t_in_word                      i_in_data,
    // result word channel
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output tmsn_pkg::t_out_word                     o_out_data,
    // register write channel
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [tmsn_pkg::C_CFG_IDX_BITS-1:0]     i_cfg_index,
    input  tmsn_pkg::t_sample                       i_cfg_data
);
    import tmsn_pkg::*;

    // configuration registers
    t_sample                   r_full;
    t_sample [C_LANES-1:0]     r_floor;

    // round position, 0 .. round length - 1
    logic [C_ROUND_BITS-1:0]   r_round;

    t_sample [C_LANES-1:0]     samples;
    t_round_stat [C_LANES-1:0] round_stat;
    t_lane_stat [C_LANES-1:0]  lane_stat;
    logic                      take;
    logic                      last;
    logic                      start;
    logic                      any_busy;
    logic                      ack;

    assign samples[0] = i_in_data.sample_ch0;
    assign samples[1] = i_in_data.sample_ch1;
    assign samples[2] = i_in_data.sample_ch2;
    assign samples[3] = i_in_data.sample_ch3;
    assign samples[4] = i_in_data.sample_ch4;

    // the round closes on its last word; that word needs all lanes free
    always_comb begin
        any_busy = 1'b0;
        for (int c = 0; c < C_LANES; c++) begin
            any_busy = any_busy | lane_stat[c].busy;
        end
    end

    assign last       = (r_round == C_ROUND_BITS'(C_ROUND_LEN - 1));
    assign o_in_stall = last && any_busy;
    assign take       = i_in_valid && !o_in_stall;
    assign start      = take && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round <= '0;
        end else if (take) begin
            r_round <= last ? '0 : r_round + 1'b1;
        end
    end

    // register writes are always taken; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full  <= C_FULL_RESET;
            r_floor <= {C_LANES{C_FLOOR_RESET}};
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_FULL_SCALE) begin
                r_full <= i_cfg_data;
            end
            for (int c = 0; c < C_LANES; c++) begin
                if (i_cfg_index == REG_FLOOR_CH0 + C_CFG_IDX_BITS'(c)) begin
                    r_floor[c] <= i_cfg_data;
                end
            end
        end
    end

    // one accumulator and one level divider per channel
    for (genvar g = 0; g < C_LANES; g++) begin : g_lane
        tmsn_acc u_acc (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_take   (take),
            .i_last   (last),
            .i_sample (samples[g]),
            .o_round  (round_stat[g])
        );

        tmsn_level u_level (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_start  (start),
            .i_round  (round_stat[g]),
            .i_full   (r_full),
            .i_floor  (r_floor[g]),
            .i_ack    (ack),
            .o_stat   (lane_stat[g])
        );
    end

    // gathers the five levels into one result word once every lane is done
    tmsn_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stat      (lane_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_ack       (ack)
    );

endmodule

FILE: src/tmsn_checker.sv
`include "trimmed_mean_sensor_normalizer_top_macros.svh"

module tmsn_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tmsn_pkg::t_out_word o_out_data
);
    import tmsn_pkg::*;

    logic [C_ROUND_BITS-1:0] r_cnt;

    // words accepted within the current round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_in_valid && !o_in_stall) begin
            r_cnt <= (r_cnt == C_ROUND_BITS'(C_ROUND_LEN - 1)) ? '0 : r_cnt + 1'b1;
        end
    end

    `TMSN_CHK_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped under stall")
    `TMSN_CHK_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_data), "stalled result changed")
    `TMSN_CHK_IMP(a_stall_at_close, o_in_stall, r_cnt == C_ROUND_BITS'(C_ROUND_LEN - 1), "input stalled mid round")
    `TMSN_CHK_IMP(a_level_top, o_out_valid, (o_out_data.level_ch0 <= C_LEVEL_BITS'(C_LEVEL_TOP)) && (o_out_data.level_ch1 <= C_LEVEL_BITS'(C_LEVEL_TOP)) && (o_out_data.level_ch2 <= C_LEVEL_BITS'(C_LEVEL_TOP)) && (o_out_data.level_ch3 <= C_LEVEL_BITS'(C_LEVEL_TOP)) && (o_out_data.level_ch4 <= C_LEVEL_BITS'(C_LEVEL_TOP)), "level above top")
    `TMSN_CHK_IMP(a_bad_zero, o_out_valid && o_out_data.bad_range, (o_out_data.level_ch0 == '0) || (o_out_data.level_ch1 == '0) || (o_out_data.level_ch2 == '0) || (o_out_data.level_ch3 == '0) || (o_out_data.level_ch4 == '0), "bad range without a zero level")

endmodule

bind trimmed_mean_sensor_normalizer_top tmsn_checker u_tmsn_checker (.*);

FILE: sim/trimmed_mean_sensor_normalizer_top_tb.sv
`timescale 1ns / 100ps

module trimmed_mean_sensor_normalizer_top_tb;

    import tmsn_pkg::*;

    // run control
    localparam int unsigned RUN_LIMIT    = 300000;
    localparam int          QUIET_CYCLES = 16;
    localparam int          MAX_REPORTS  = 10;
    localparam int          PHASES       = 12;

    typedef logic [C_LEVEL_BITS-1:0] t_level_set [C_LANES];

    // unpack the five channel levels of a result word
    function automatic t_level_set levels_of(t_out_word w);
        return '{w.level_ch0, w.level_ch1, w.level_ch2, w.level_ch3, w.level_ch4};
    endfunction

    // olympic-filter level predictor plus the queue of level words still owed
    class level_board;
        t_sample               full_scale;
        t_sample               floor_lvl [C_LANES];
        int unsigned           taken;
        logic [C_SUM_BITS-1:0] run_sum [C_LANES];
        t_sample               run_min [C_LANES];
        t_sample               run_max [C_LANES];
        t_out_word             level_queue [$];
        int unsigned           words_in;
        int unsigned           words_out;
        int unsigned           mismatches;

        function new();
            full_scale = C_FULL_RESET;
            foreach (floor_lvl[c])
                floor_lvl[c] = C_FLOOR_RESET;
            words_in   = 0;
            words_out  = 0;
            mismatches = 0;
            clear_round();
        endfunction

        function void clear_round();
            taken = 0;
            foreach (run_sum[c]) begin
                run_sum[c] = '0;
                run_min[c] = '1;
                run_max[c] = '0;
            end
        endfunction

        // register write as the block sees it; unused indexes fall through
        function void apply_reg(logic [C_CFG_IDX_BITS-1:0] idx, t_sample val);
            if (idx == REG_FULL_SCALE) begin
                full_scale = val;
            end else if (idx <= REG_FLOOR_CH4) begin
                floor_lvl[idx - REG_FLOOR_CH0] = val;
            end
        endfunction

        // inverted level, exact integer form, clamped; an empty range gives zero, the caller flags it
        function logic [C_LEVEL_BITS-1:0] lane_level(logic [C_SUM_BITS-1:0] mid, t_sample lo);
            longint num;
            longint den;
            longint q;
            if (lo >= full_scale)
                return '0;
            num = C_SCALE_TOP * longint'(full_scale) - C_SCALE_MID * longint'(mid);
            if (num < 0)
                return '0;
            den = C_DEN_MUL * (longint'(full_scale) - longint'(lo));
            q = num / den;
            if (q > C_LEVEL_TOP)
                q = C_LEVEL_TOP;
            return q[C_LEVEL_BITS-1:0];
        endfunction

        function void take_samples(t_in_word w);
            t_sample               s [C_LANES];
            logic [C_SUM_BITS-1:0] mid;
            t_level_set            lv;
            t_out_word             want;
            bit                    bad;
            s = '{w.sample_ch0, w.sample_ch1, w.sample_ch2, w.sample_ch3, w.sample_ch4};
            words_in++;
            foreach (s[c]) begin
                run_sum[c] += s[c];
                if (s[c] < run_min[c])
                    run_min[c] = s[c];
                if (s[c] > run_max[c])
                    run_max[c] = s[c];
            end
            taken++;
            if (taken < C_ROUND_LEN)
                return;
            bad = 1'b0;
            foreach (lv[c]) begin
                mid = run_sum[c] - run_min[c] - run_max[c];
                if (floor_lvl[c] >= full_scale)
                    bad = 1'b1;
                lv[c] = lane_level(mid, floor_lvl[c]);
            end
            want.level_ch0 = lv[0];
            want.level_ch1 = lv[1];
            want.level_ch2 = lv[2];
            want.level_ch3 = lv[3];
            want.level_ch4 = lv[4];
            want.bad_range = bad;
            level_queue.push_back(want);
            clear_round();
        endfunction

        function void check_levels(t_out_word got);
            t_out_word  want;
            t_level_set got_lv;
            t_level_set want_lv;
            bit         wrong;
            words_out++;
            got_lv = levels_of(got);
            if (level_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected level word %0d %0d %0d %0d %0d bad %0b", $time,
                             got_lv[0], got_lv[1], got_lv[2], got_lv[3], got_lv[4],
                             got.bad_range);
                return;
            end
            want = level_queue.pop_front();
            want_lv = levels_of(want);
            wrong = (got.bad_range !== want.bad_range);
            foreach (got_lv[c])
                if (got_lv[c] !== want_lv[c])
                    wrong = 1'b1;
            if (wrong) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: word %0d want %0d %0d %0d %0d %0d/%0b got %0d %0d %0d %0d %0d/%0b",
                             $time, words_out,
                             want_lv[0], want_lv[1], want_lv[2], want_lv[3], want_lv[4],
                             want.bad_range,
                             got_lv[0], got_lv[1], got_lv[2], got_lv[3], got_lv[4],
                             got.bad_range);
            end
        endfunction

        function int unsigned pending();
            return level_queue.size();
        endfunction
    endclass

    // clock, reset and block-facing signals; the ones the bench drives are known from time zero
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    t_in_word                  in_data = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    t_out_word                 out_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [C_CFG_IDX_BITS-1:0] cfg_index = '0;
    t_sample                   cfg_data = '0;

    level_board  board;
    int          sender_idle_pct = 38;
    int          recv_stall_pct = 69;
    int unsigned settings_count = 0;
    int unsigned cycle_count = 0;

    always #4 clk = ~clk;

    trimmed_mean_sensor_normalizer_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // result monitor: values read here are the ones the edge sampled
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_levels(out_data);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("run stopped at the cycle limit with %0d level words owed", board.pending());
        $display("TEST FAILED");
        $finish;
    end

    task automatic set_pace(int snd, int rcv);
        sender_idle_pct = snd;
        recv_stall_pct <= rcv;
    endtask

    // one sample word; valid stays high afterwards until the next call or settle
    task automatic push_word(t_in_word w);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
        board.take_samples(w);
    endtask

    // drain every owed level word, then give an open round time to land
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [C_CFG_IDX_BITS-1:0] idx, t_sample val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.apply_reg(idx, val);
    endtask

    // full register set, plus a stray write to an unused index
    task automatic program_regs(t_sample full, t_sample floors [C_LANES]);
        write_reg(C_CFG_IDX_BITS'(REG_FLOOR_CH4 + 1 + $urandom_range(1)), t_sample'($urandom));
        write_reg(REG_FULL_SCALE, full);
        for (int c = 0; c < C_LANES; c++)
            write_reg(C_CFG_IDX_BITS'(REG_FLOOR_CH0 + c), floors[c]);
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // random register setting: extremes, anything, sane ranges, tiny full scale
    task automatic pick_setting();
        t_sample full;
        t_sample floors [C_LANES];
        case ($urandom_range(3))
            0: begin
                full = '1;
                foreach (floors[c])
                    floors[c] = '0;
                floors[$urandom_range(C_LANES - 1)] = full - 1'b1;
            end
            1: begin
                full = t_sample'($urandom);
                foreach (floors[c])
                    floors[c] = t_sample'($urandom);
            end
            2: begin
                full = t_sample'($urandom_range(1024, 4095));
                foreach (floors[c])
                    floors[c] = t_sample'($urandom_range(0, full - 1));
                floors[$urandom_range(C_LANES - 1)] = full - 1'b1;
            end
            default: begin
                full = t_sample'($urandom_range(0, 63));
                foreach (floors[c])
                    floors[c] = $urandom_range(1) ? t_sample'('1)
                                                  : t_sample'($urandom_range(0, full));
            end
        endcase
        program_regs(full, floors);
    endtask

    // sample biased toward the useful band between a channel floor and full scale
    function automatic t_sample draw_sample(t_sample lo);
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3, 4: return t_sample'($urandom);
            default: begin
                if (lo < board.full_scale)
                    return t_sample'($urandom_range(lo, board.full_scale));
                return t_sample'($urandom);
            end
        endcase
    endfunction

    function automatic t_in_word random_word();
        return '{draw_sample(board.floor_lvl[0]), draw_sample(board.floor_lvl[1]),
                 draw_sample(board.floor_lvl[2]), draw_sample(board.floor_lvl[3]),
                 draw_sample(board.floor_lvl[4])};
    endfunction

    initial begin
        t_sample zeros [C_LANES];
        t_sample mixed [C_LANES];
        int      n;
        zeros = '{default: '0};
        mixed = '{12'd0, 12'd99, 12'd100, 12'd4095, 12'd50};
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: widest range, bottom and top of scale, then crossing bit patterns
        program_regs(12'hFFF, zeros);
        repeat (5) push_word(t_in_word'{12'h000, 12'h000, 12'h000, 12'h000, 12'h000});
        repeat (5) push_word(t_in_word'{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
        push_word(t_in_word'{12'hAAA, 12'h555, 12'h000, 12'hFFF, 12'h800});
        push_word(t_in_word'{12'h555, 12'hAAA, 12'hFFF, 12'h000, 12'h7FF});
        push_word(t_in_word'{12'hFFF, 12'h000, 12'h123, 12'hABC, 12'h001});
        push_word(t_in_word'{12'h000, 12'hFFF, 12'hEDC, 12'h543, 12'hFFE});
        push_word(t_in_word'{12'h800, 12'h7FF, 12'h555, 12'hAAA, 12'h400});
        settle();

        // narrow full scale: negative numerator, saturation, floor equal and above top
        program_regs(12'd100, mixed);
        push_word(t_in_word'{12'hFFF, 12'h000, 12'd50, 12'd50, 12'd25});
        push_word(t_in_word'{12'hFFF, 12'h000, 12'd40, 12'd60, 12'd20});
        push_word(t_in_word'{12'hFFE, 12'h001, 12'd50, 12'd50, 12'd30});
        push_word(t_in_word'{12'hFFF, 12'h000, 12'd55, 12'd45, 12'd25});
        push_word(t_in_word'{12'hC00, 12'h002, 12'd50, 12'd50, 12'd25});
        settle();

        // registers rewritten in the middle of a round; zero full scale flags every channel
        push_word(t_in_word'{12'h010, 12'h020, 12'h030, 12'h040, 12'h050});
        push_word(t_in_word'{12'h011, 12'h021, 12'h031, 12'h041, 12'h051});
        settle();
        program_regs(12'd0, zeros);
        push_word(t_in_word'{12'h012, 12'h022, 12'h032, 12'h042, 12'h052});
        push_word(t_in_word'{12'h013, 12'h023, 12'h033, 12'h043, 12'h053});
        push_word(t_in_word'{12'h014, 12'h024, 12'h034, 12'h044, 12'h054});

        // random phases: throttled both ways, swapped, then full rate
        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES / 3)
                set_pace(69, 38);
            if (p == 2 * PHASES / 3)
                set_pace(0, 0);
            settle();
            pick_setting();
            n = $urandom_range(25, 45);
            repeat (n) push_word(random_word());
        end
        settle();

        $display("%0d sample words in, %0d level words checked over %0d register settings",
                 board.words_in, board.words_out, settings_count);
        $display("pacing went throttled, swapped, then full rate; %0d mismatches",
                 board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
